FILE: src/svs_pkg.sv
// ----------------------------------------------------------------------------
// svs_pkg - shared types and constants of the shadow variable sync block
// Opcodes, event kinds, register indexes, configuration and queue entry
// types used by the front, queue and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package svs_pkg;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SERVER = 2'd1,
    OP_CLIENT = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  // Result event kinds
  typedef enum logic [1:0] {
    EVT_VALUE  = 2'd0,
    EVT_ASSERT = 2'd1,
    EVT_SEND   = 2'd2
  } evt_kind_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_STALE_TIMEOUT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ASSERT_WAIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEND_ENABLE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SEND_WAIT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_VALUE = 3'd4;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned EventW   = 32;
  localparam int unsigned MaxEvents = 4;
  localparam int unsigned EvIdxW   = 2;
  localparam int unsigned EvCntW   = 3;

  // Configuration as seen by the front and back
  typedef struct packed {
    logic [TimeW-1:0] stale_timeout;
    logic [TimeW-1:0] assert_wait;
    logic             send_enable;
    logic [TimeW-1:0] send_wait;
  } cfg_t;

  // Classified item held in the queue
  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] assert_dl;
    logic [TimeW-1:0] send_dl;
  } item_t;

  // One result event
  typedef struct packed {
    evt_kind_e         kind;
    logic [EventW-1:0] value;
    logic              equal;
    logic              stale;
    logic              last;
  } event_t;

endpackage

`default_nettype wire

FILE: src/svs_front.sv
// ----------------------------------------------------------------------------
// svs_front - input side of the shadow variable sync block
// Decodes the opcode, drops unused opcodes, masks the value and precomputes
// the assert and send deadlines for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [svs_pkg::TimeW-1:0]    now_ms_i,
  input  wire logic [31:0]                  data_value_i,
  input  wire svs_pkg::cfg_t                cfg_i,
  output logic                              push_valid_o,
  input  wire logic                         push_full_i,
  output svs_pkg::item_t                    push_item_o,
  output logic [VALUE_WIDTH-1:0]            push_data_o
);
  import svs_pkg::*;

  op_e         op;
  logic [63:0] data_ext;

  // Decode opcode and mask the value to the stored width
  always_comb begin
    op       = op_e'(opcode_i);
    data_ext = 64'(data_value_i);
  end

  // Hold input while the queue is full; an unused opcode is taken and dropped
  assign in_stall_o   = push_full_i;
  assign push_valid_o = in_valid_i && (op != OP_UNUSED);
  assign push_data_o  = data_ext[VALUE_WIDTH-1:0];

  // Arm deadlines ahead of time; the user must make configuration changes only while idle, unchecked by the block
  always_comb begin
    push_item_o.op        = op;
    push_item_o.now       = now_ms_i;
    push_item_o.assert_dl = now_ms_i + cfg_i.assert_wait;
    push_item_o.send_dl   = now_ms_i + cfg_i.send_wait;
  end

endmodule

`default_nettype wire

FILE: src/svs_queue.sv
// ----------------------------------------------------------------------------
// svs_queue - two-entry queue between front and back
// Decouples input acceptance from event generation.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_queue #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_valid_i,
  output logic                        full_o,
  input  wire svs_pkg::item_t         push_item_i,
  input  wire logic [VALUE_WIDTH-1:0] push_data_i,
  output logic                        pop_valid_o,
  input  wire logic                   pop_i,
  output svs_pkg::item_t              pop_item_o,
  output logic [VALUE_WIDTH-1:0]      pop_data_o
);
  import svs_pkg::*;

  item_t                  item_q [2];
  logic [VALUE_WIDTH-1:0] data_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push, pop;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_i && pop_valid_o;
  assign pop_item_o  = item_q[rd_ptr_q];
  assign pop_data_o  = data_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q] <= push_item_i;
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/svs_back.sv
// ----------------------------------------------------------------------------
// svs_back - state and event side of the shadow variable sync block
// Applies one queued item to the shadow state and serializes the resulting
// events through an event buffer that doubles as the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire svs_pkg::cfg_t          cfg_i,
  input  wire logic                   pop_valid_i,
  output logic                        pop_o,
  input  wire svs_pkg::item_t         pop_item_i,
  input  wire logic [VALUE_WIDTH-1:0] pop_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output svs_pkg::event_t             out_event_o
);
  import svs_pkg::*;

  // Shadow state
  logic [VALUE_WIDTH-1:0] client_q, client_d;
  logic [VALUE_WIDTH-1:0] server_q, server_d;
  logic                   stale_q, stale_d;
  logic [TimeW-1:0]       last_srv_q, last_srv_d;
  logic [TimeW-1:0]       assert_dl_q, assert_dl_d;
  logic                   assert_done_q, assert_done_d;
  logic [TimeW-1:0]       send_dl_q, send_dl_d;
  logic                   send_done_q, send_done_d;

  // Event buffer
  event_t                 ev_q [MaxEvents];
  event_t                 ev_n [MaxEvents];
  logic [EvCntW-1:0]      cnt_q, cnt_n;
  logic [EvIdxW-1:0]      rd_q;

  logic                   xfer;
  logic                   load;
  logic [TimeW-1:0]       age;
  logic                   equal;
  logic [63:0]            cv_ext, sv_ext, dv_ext;
  logic [EventW-1:0]      val32;

  assign out_valid_o = (cnt_q != '0);
  assign out_event_o = ev_q[rd_q];
  assign xfer        = out_valid_o && !out_stall_i;
  assign load        = (cnt_q == '0) || ((cnt_q == EvCntW'(1)) && xfer);
  assign pop_o       = load && pop_valid_i;

  assign age    = pop_item_i.now - last_srv_q;
  assign equal  = (client_q == server_q);
  assign cv_ext = 64'(client_q);
  assign sv_ext = 64'(server_q);
  assign dv_ext = 64'(pop_data_i);

  // Apply the head item: next state and its list of events
  always_comb begin
    client_d      = client_q;
    server_d      = server_q;
    stale_d       = stale_q;
    last_srv_d    = last_srv_q;
    assert_dl_d   = assert_dl_q;
    assert_done_d = assert_done_q;
    send_dl_d     = send_dl_q;
    send_done_d   = send_done_q;
    cnt_n         = '0;
    val32         = cv_ext[EventW-1:0];
    for (int i = 0; i < MaxEvents; i++) begin
      ev_n[i] = '0;
    end

    unique case (pop_item_i.op)
      OP_TICK: begin
        // Mark stale after the timeout
        if ((age > cfg_i.stale_timeout) && !stale_q) begin
          stale_d = 1'b1;
          ev_n[cnt_n[EvIdxW-1:0]] = '{kind: EVT_VALUE, value: val32, equal: 1'b0,
                                      stale: 1'b1, last: 1'b0};
          cnt_n = cnt_n + EvCntW'(1);
        end
        // Reconcile with the server value at the assert deadline
        if ((pop_item_i.now > assert_dl_q) && !assert_done_q) begin
          val32 = sv_ext[EventW-1:0];
          if (!equal) begin
            client_d = server_q;
            ev_n[cnt_n[EvIdxW-1:0]] = '{kind: EVT_VALUE, value: val32, equal: 1'b0,
                                        stale: stale_d, last: 1'b0};
            cnt_n = cnt_n + EvCntW'(1);
          end
          ev_n[cnt_n[EvIdxW-1:0]] = '{kind: EVT_ASSERT, value: val32, equal: equal,
                                      stale: stale_d, last: 1'b0};
          cnt_n = cnt_n + EvCntW'(1);
          assert_done_d = 1'b1;
        end
        // Emit the delayed send
        if (cfg_i.send_enable && (pop_item_i.now > send_dl_q) && !send_done_q) begin
          ev_n[cnt_n[EvIdxW-1:0]] = '{kind: EVT_SEND, value: val32, equal: 1'b0,
                                      stale: stale_d, last: 1'b0};
          cnt_n = cnt_n + EvCntW'(1);
          send_done_d = 1'b1;
        end
      end
      OP_SERVER: begin
        server_d   = pop_data_i;
        stale_d    = 1'b0;
        last_srv_d = pop_item_i.now;
        if (assert_done_q && (client_q != pop_data_i)) begin
          client_d = pop_data_i;
          ev_n[0]  = '{kind: EVT_VALUE, value: dv_ext[EventW-1:0], equal: 1'b0,
                       stale: 1'b0, last: 1'b0};
          cnt_n    = EvCntW'(1);
        end
      end
      OP_CLIENT: begin
        client_d = pop_data_i;
        if (cfg_i.send_enable) begin
          send_dl_d   = pop_item_i.send_dl;
          send_done_d = 1'b0;
        end
        assert_dl_d   = pop_item_i.assert_dl;
        assert_done_d = 1'b0;
        if (client_q != pop_data_i) begin
          ev_n[0] = '{kind: EVT_VALUE, value: dv_ext[EventW-1:0], equal: 1'b0,
                      stale: stale_q, last: 1'b0};
          cnt_n   = EvCntW'(1);
        end
      end
      default: begin
        // Unused opcode never reaches the queue
      end
    endcase

    // Flag the final event of this item
    for (int i = 0; i < MaxEvents; i++) begin
      ev_n[i].last = (EvCntW'(i) + EvCntW'(1) == cnt_n);
    end
  end

  // Update shadow state on each popped item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      client_q      <= '0;
      server_q      <= '0;
      stale_q       <= 1'b0;
      last_srv_q    <= '0;
      assert_dl_q   <= '0;
      assert_done_q <= 1'b1;
      send_dl_q     <= '0;
      send_done_q   <= 1'b1;
    end else if (pop_o) begin
      client_q      <= client_d;
      server_q      <= server_d;
      stale_q       <= stale_d;
      last_srv_q    <= last_srv_d;
      assert_dl_q   <= assert_dl_d;
      assert_done_q <= assert_done_d;
      send_dl_q     <= send_dl_d;
      send_done_q   <= send_done_d;
    end
  end

  // Load a new event list or advance through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load) begin
      cnt_q <= pop_valid_i ? cnt_n : '0;
      rd_q  <= '0;
    end else if (xfer) begin
      cnt_q <= cnt_q - EvCntW'(1);
      rd_q  <= rd_q + EvIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < MaxEvents; i++) begin
        ev_q[i] <= ev_n[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/server_shadow_variable_sync.sv
// ----------------------------------------------------------------------------
// server_shadow_variable_sync - client shadow of a server-owned value
// Configuration registers, front decode, two-entry queue and back state.
// ----------------------------------------------------------------------------
// Path: an item goes into the queue and is popped into the event buffer, whose
//   head is the output register, when the buffer is empty or sends its last event.
// Events: the back unit passes the up to four events of an item out in order, and
//   holds them while the output stalls; an item with no event is popped without output.
// Reset: shadow state, control and configuration registers load their reset
//   values at once; queue and event buffer storage are not reset. The client copy
//   resets to zero, and a write to the initial_value index has no effect.
`default_nettype none

module server_shadow_variable_sync #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [svs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                 cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [31:0]                 now_ms_i,
  input  wire logic [31:0]                 data_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       event_kind_o,
  output logic [31:0]                      event_value_o,
  output logic                             assert_equal_o,
  output logic                             stale_flag_o,
  output logic                             last_event_o
);
  import svs_pkg::*;

  cfg_t                   cfg_q;
  logic                   push_valid;
  logic                   q_full;
  item_t                  push_item;
  logic [VALUE_WIDTH-1:0] push_data;
  logic                   pop_valid;
  logic                   pop;
  item_t                  pop_item;
  logic [VALUE_WIDTH-1:0] pop_data;
  event_t                 out_event;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_timeout <= 32'd60000;
      cfg_q.assert_wait   <= 32'd5000;
      cfg_q.send_enable   <= 1'b0;
      cfg_q.send_wait     <= 32'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STALE_TIMEOUT: cfg_q.stale_timeout <= cfg_data_i;
        CFG_ASSERT_WAIT:   cfg_q.assert_wait   <= cfg_data_i;
        CFG_SEND_ENABLE:   cfg_q.send_enable   <= cfg_data_i[0];
        CFG_SEND_WAIT:     cfg_q.send_wait     <= cfg_data_i;
        CFG_INITIAL_VALUE: begin
          // A write to this index has no effect; the client copy resets to zero
        end
        default: begin
        end
      endcase
    end
  end

  svs_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .now_ms_i     (now_ms_i),
    .data_value_i (data_value_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_full_i  (q_full),
    .push_item_o  (push_item),
    .push_data_o  (push_data)
  );

  svs_queue #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .full_o       (q_full),
    .push_item_i  (push_item),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item),
    .pop_data_o   (pop_data)
  );

  svs_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_event_o (out_event)
  );

  // Drive result fields
  assign event_kind_o   = out_event.kind;
  assign event_value_o  = out_event.value;
  assign assert_equal_o = out_event.equal;
  assign stale_flag_o   = out_event.stale;
  assign last_event_o   = out_event.last;

endmodule

`default_nettype wire

FILE: src/svs_checker.sv
// ----------------------------------------------------------------------------
// svs_checker - port-level checks of the shadow variable sync block
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  event_kind_o,
  input wire logic [31:0] event_value_o,
  input wire logic        assert_equal_o,
  input wire logic        last_event_o
);
  import svs_pkg::*;

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(event_value_o) && $stable(event_kind_o))
    else $error("stalled result changed");

  // Equality flag only on assert results
  a_equal_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != EVT_ASSERT) |-> !assert_equal_o)
    else $error("assert_equal set on a non-assert event");

  // A send request always closes its item
  a_send_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EVT_SEND) |-> last_event_o)
    else $error("send request not marked last");

endmodule

bind server_shadow_variable_sync svs_checker u_checker (.*);

`default_nettype wire
